// File: rtl/core/ugae_pkg.sv
// shared types and constants for the unitary gate apply engine
// no dependencies
package ugae_pkg;

   localparam int MAX_QUBITS_DEFAULT = 4;
   localparam logic [31:0] Q_ONE = 32'h4000_0000;

   localparam logic [2:0] OP_IDENTITY  = 3'd0;
   localparam logic [2:0] OP_WRITE     = 3'd1;
   localparam logic [2:0] OP_READ      = 3'd2;
   localparam logic [2:0] OP_LOAD_GATE = 3'd3;
   localparam logic [2:0] OP_APPLY_TWO = 3'd4;
   localparam logic [2:0] OP_APPLY_ONE = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_PAIR  = 2'd2;
   localparam logic [1:0] ST_ONEQ  = 2'd3;

   localparam logic [1:0] TERM_RR = 2'd0;
   localparam logic [1:0] TERM_II = 2'd1;
   localparam logic [1:0] TERM_RI = 2'd2;
   localparam logic [1:0] TERM_IR = 2'd3;

   localparam logic [1:0] WR_REQ  = 2'd0;
   localparam logic [1:0] WR_ONE  = 2'd1;
   localparam logic [1:0] WR_ZERO = 2'd2;
   localparam logic [1:0] WR_ACC  = 2'd3;

   typedef struct packed {
      logic       store_rd;
      logic       store_wr;
      logic [1:0] wr_sel;
      logic [1:0] k_dst;
      logic       mac;
      logic [3:0] gate_idx;
      logic [1:0] term;
      logic       acc_clr;
      logic       gate_we;
      logic       rsp_load;
      logic       rsp_read;
   } cmd_type;

endpackage

// File: rtl/core/ugae_datapath.sv
// datapath: unitary store, gate store, multiplier and accumulators
// depends on ugae_pkg
module ugae_datapath #(
   parameter int MAX_QUBITS = ugae_pkg::MAX_QUBITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ugae_pkg::cmd_type         cmd,
   input  logic [2*MAX_QUBITS-1:0]   addr,
   input  logic signed [31:0]        req_value_real,
   input  logic signed [31:0]        req_value_imag,
   output logic signed [31:0]        rsp_read_real,
   output logic signed [31:0]        rsp_read_imag
);
   localparam int DEPTH = 1 << (2 * MAX_QUBITS);

   logic [63:0] store_mem [DEPTH];
   logic [63:0] gate_mem [16];
   logic [63:0] old_ff [4];

   logic signed [63:0] prod_ff;
   logic               prod_valid_ff;
   logic               prod_im_ff;
   logic               prod_neg_ff;
   logic signed [66:0] acc_re_ff, acc_im_ff;
   logic signed [31:0] rd_re_ff, rd_im_ff;

   logic signed [31:0] op_a, op_b;
   logic [63:0]        g_sel, m_sel, wdata;
   logic signed [66:0] p_ext;

   function automatic logic [31:0] sat_q(input logic signed [66:0] a);
      logic [36:0] s;
      s = a[66:30];
      if (!s[36] && (|s[35:31]))
         sat_q = 32'h7fff_ffff;
      else if (s[36] && !(&s[35:31]))
         sat_q = 32'h8000_0000;
      else
         sat_q = s[31:0];
   endfunction

   always_comb begin
      g_sel = gate_mem[cmd.gate_idx];
      m_sel = old_ff[cmd.k_dst];
      case (cmd.term)
         ugae_pkg::TERM_RR: begin op_a = g_sel[31:0];  op_b = m_sel[31:0];  end
         ugae_pkg::TERM_II: begin op_a = g_sel[63:32]; op_b = m_sel[63:32]; end
         ugae_pkg::TERM_RI: begin op_a = g_sel[31:0];  op_b = m_sel[63:32]; end
         default:           begin op_a = g_sel[63:32]; op_b = m_sel[31:0];  end
      endcase
      p_ext = {{3{prod_ff[63]}}, prod_ff};
      if (prod_neg_ff)
         p_ext = -p_ext;
      case (cmd.wr_sel)
         ugae_pkg::WR_REQ:  wdata = {req_value_imag, req_value_real};
         ugae_pkg::WR_ONE:  wdata = {32'd0, ugae_pkg::Q_ONE};
         ugae_pkg::WR_ZERO: wdata = 64'd0;
         default:           wdata = {sat_q(acc_im_ff), sat_q(acc_re_ff)};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.store_wr)
         store_mem[addr] <= wdata;
      if (cmd.store_rd)
         old_ff[cmd.k_dst] <= store_mem[addr];
      if (cmd.gate_we)
         gate_mem[cmd.gate_idx] <= {req_value_imag, req_value_real};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.mac;
      end
      prod_ff     <= op_a * op_b;
      prod_im_ff  <= (cmd.term == ugae_pkg::TERM_RI) || (cmd.term == ugae_pkg::TERM_IR);
      prod_neg_ff <= (cmd.term == ugae_pkg::TERM_II);
      if (cmd.acc_clr) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_valid_ff) begin
         if (prod_im_ff)
            acc_im_ff <= acc_im_ff + p_ext;
         else
            acc_re_ff <= acc_re_ff + p_ext;
      end
      if (cmd.rsp_load) begin
         rd_re_ff <= cmd.rsp_read ? old_ff[0][31:0]  : 32'sd0;
         rd_im_ff <= cmd.rsp_read ? old_ff[0][63:32] : 32'sd0;
      end
   end

   assign rsp_read_real = rd_re_ff;
   assign rsp_read_imag = rd_im_ff;

endmodule

// File: rtl/core/ugae_controller.sv
// controller: operation decode, qubit count register, block sequencer
// depends on ugae_pkg
module ugae_controller #(
   parameter int MAX_QUBITS = ugae_pkg::MAX_QUBITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_operation,
   input  logic [3:0]                req_row,
   input  logic [3:0]                req_col,
   input  logic [3:0]                req_gate_slot,
   input  logic [1:0]                req_first_qubit,
   input  logic [1:0]                req_second_qubit,
   input  logic                      csr_we,
   input  logic [2:0]                csr_wdata,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output ugae_pkg::cmd_type         cmd,
   output logic [2*MAX_QUBITS-1:0]   addr
);
   localparam int IW = MAX_QUBITS;
   localparam int CW = (IW > 4 ? IW : 4) + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_IDENT = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_MAC   = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_WB    = 3'd6;
   localparam logic [2:0] S_SEEK  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    qcount_ff;
   logic [IW-1:0] base_ff, base_in, col_ff, col_in;
   logic [IW-1:0] bj_ff, bj_in, bk_ff, bk_in, mask_ff, mask_in;
   logic [1:0]    k_ff, k_in, r_ff, r_in, t_ff, t_in;
   logic          cnt4_ff, cnt4_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;

   logic [3:0]    n_act;
   logic [CW-1:0] dim;
   logic          accept, in_range, pair_ok;
   logic [1:0]    last_k;
   logic [IW-1:0] row_k, row_r;

   always_comb begin
      if (qcount_ff == 3'd0)
         n_act = 4'd1;
      else if (4'(qcount_ff) > 4'(MAX_QUBITS))
         n_act = 4'(MAX_QUBITS);
      else
         n_act = 4'(qcount_ff);
      dim      = CW'(1) << n_act;
      accept   = start && (state_ff == S_IDLE);
      in_range = (CW'(req_row) < dim) && (CW'(req_col) < dim);
      pair_ok  = (req_first_qubit < req_second_qubit) && (4'(req_second_qubit) < n_act);
      last_k   = cnt4_ff ? 2'd3 : 2'd1;
      row_k    = base_ff | (k_ff[1] ? bj_ff : '0) | (k_ff[0] ? bk_ff : '0);
      row_r    = base_ff | (r_ff[1] ? bj_ff : '0) | (r_ff[0] ? bk_ff : '0);
   end

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      bj_in        = bj_ff;
      bk_in        = bk_ff;
      mask_in      = mask_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      cnt4_in      = cnt4_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      cmd          = '0;
      addr         = {IW'(req_row), IW'(req_col)};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mask_in   = IW'(dim - CW'(1));
               base_in   = '0;
               col_in    = '0;
               k_in      = 2'd0;
               status_in = ugae_pkg::ST_OK;
               unique case (req_operation) inside
                  ugae_pkg::OP_IDENTITY: state_in = S_IDENT;
                  ugae_pkg::OP_WRITE, ugae_pkg::OP_READ: begin
                     if (!in_range) begin
                        status_in = ugae_pkg::ST_RANGE;
                     end else if (req_operation == ugae_pkg::OP_WRITE) begin
                        cmd.store_wr = 1'b1;
                        cmd.wr_sel   = ugae_pkg::WR_REQ;
                     end else begin
                        cmd.store_rd = 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  ugae_pkg::OP_LOAD_GATE: begin
                     cmd.gate_we  = 1'b1;
                     cmd.gate_idx = req_gate_slot;
                  end
                  ugae_pkg::OP_APPLY_TWO: begin
                     if (!pair_ok) begin
                        status_in = ugae_pkg::ST_PAIR;
                     end else begin
                        cnt4_in  = 1'b1;
                        bj_in    = IW'(1) << (n_act - 4'd1 - 4'(req_first_qubit));
                        bk_in    = IW'(1) << (n_act - 4'd1 - 4'(req_second_qubit));
                        state_in = S_LOAD;
                     end
                  end
                  ugae_pkg::OP_APPLY_ONE: begin
                     if (n_act != 4'd1) begin
                        status_in = ugae_pkg::ST_ONEQ;
                     end else begin
                        cnt4_in  = 1'b0;
                        bj_in    = '0;
                        bk_in    = IW'(1);
                        state_in = S_LOAD;
                     end
                  end
                  default: status_in = ugae_pkg::ST_RANGE;
               endcase
               if (state_in == S_IDLE) begin
                  rsp_valid_in = 1'b1;
                  cmd.rsp_load = 1'b1;
               end
            end
         end
         S_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_read = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_IDENT: begin
            addr         = {base_ff, col_ff};
            cmd.store_wr = 1'b1;
            cmd.wr_sel   = (base_ff == col_ff) ? ugae_pkg::WR_ONE : ugae_pkg::WR_ZERO;
            if (col_ff == mask_ff) begin
               col_in = '0;
               if (base_ff == mask_ff) begin
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  base_in = base_ff + IW'(1);
               end
            end else begin
               col_in = col_ff + IW'(1);
            end
         end
         S_LOAD: begin
            addr         = {row_k, col_ff};
            cmd.store_rd = 1'b1;
            cmd.k_dst    = k_ff;
            cmd.acc_clr  = 1'b1;
            if (k_ff == last_k) begin
               k_in     = 2'd0;
               r_in     = 2'd0;
               t_in     = 2'd0;
               state_in = S_MAC;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_MAC: begin
            cmd.mac      = 1'b1;
            cmd.k_dst    = k_ff;
            cmd.term     = t_ff;
            cmd.gate_idx = cnt4_ff ? {r_ff, k_ff} : {2'b00, r_ff[0], k_ff[0]};
            t_in         = t_ff + 2'd1;
            if (t_ff == 2'd3) begin
               k_in = k_ff + 2'd1;
               if (k_ff == last_k) begin
                  k_in     = 2'd0;
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: state_in = S_WB;
         S_WB: begin
            addr         = {row_r, col_ff};
            cmd.store_wr = 1'b1;
            cmd.wr_sel   = ugae_pkg::WR_ACC;
            cmd.acc_clr  = 1'b1;
            if (r_ff == last_k) begin
               if (col_ff == mask_ff) begin
                  col_in = '0;
                  if (base_ff == mask_ff) begin
                     cmd.rsp_load = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     base_in  = base_ff + IW'(1);
                     state_in = S_SEEK;
                  end
               end else begin
                  col_in   = col_ff + IW'(1);
                  state_in = S_LOAD;
               end
            end else begin
               r_in     = r_ff + 2'd1;
               state_in = S_MAC;
            end
         end
         S_SEEK: begin
            if ((base_ff & (bj_ff | bk_ff)) == '0) begin
               state_in = S_LOAD;
            end else if (base_ff == mask_ff) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               base_in = base_ff + IW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         qcount_ff    <= 3'd1;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ugae_pkg::ST_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         if (csr_we)
            qcount_ff <= csr_wdata;
      end
      base_ff <= base_in;
      col_ff  <= col_in;
      bj_ff   <= bj_in;
      bk_ff   <= bk_in;
      mask_ff <= mask_in;
      k_ff    <= k_in;
      r_ff    <= r_in;
      t_ff    <= t_in;
      cnt4_ff <= cnt4_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

   a_no_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.store_rd && cmd.store_wr))
      else $error("store read and write in one cycle");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while sequencer active");
   a_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither running nor answered");
   a_gate_ok: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == ugae_pkg::OP_LOAD_GATE)
      |=> (rsp_valid && rsp_status == ugae_pkg::ST_OK))
      else $error("gate load not answered ok");

endmodule

// File: rtl/core/unitary_gate_apply_engine.sv
// top level of the unitary gate apply engine
// depends on ugae_pkg, ugae_controller, ugae_datapath
//
// A transaction is taken when start is high and busy low; each one gives a
// single response strobe (rsp_valid) one cycle wide, which the receiver cannot
// stall. Write, load-gate and rejected transactions answer from the idle state,
// a read from S_READ after its store read, identity once it has written every
// element of the active block. Applying a gate runs blocks of c rows (c = 4 for
// two qubits, 2 for one) of one column: c store reads, then for each row 4c
// partial products on the single 32x32 multiplier (one partial product a cycle,
// then drain and writeback); base rows holding a target qubit bit are skipped.
module unitary_gate_apply_engine #(
   parameter int MAX_QUBITS = ugae_pkg::MAX_QUBITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [3:0]         req_row,
   input  logic [3:0]         req_col,
   input  logic signed [31:0] req_value_real,
   input  logic signed [31:0] req_value_imag,
   input  logic [3:0]         req_gate_slot,
   input  logic [1:0]         req_first_qubit,
   input  logic [1:0]         req_second_qubit,
   input  logic               csr_we,
   input  logic [2:0]         csr_wdata,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_real,
   output logic signed [31:0] rsp_read_imag,
   output logic [1:0]         rsp_status
);
   ugae_pkg::cmd_type       cmd;
   logic [2*MAX_QUBITS-1:0] addr;

   ugae_controller #(.MAX_QUBITS(MAX_QUBITS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_gate_slot    (req_gate_slot),
      .req_first_qubit  (req_first_qubit),
      .req_second_qubit (req_second_qubit),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .addr             (addr)
   );

   ugae_datapath #(.MAX_QUBITS(MAX_QUBITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .addr           (addr),
      .req_value_real (req_value_real),
      .req_value_imag (req_value_imag),
      .rsp_read_real  (rsp_read_real),
      .rsp_read_imag  (rsp_read_imag)
   );

endmodule

// File: dv/unitary_gate_apply_engine_test.sv
// self-checking testbench for the unitary gate apply engine
// depends on ugae_pkg and the unitary_gate_apply_engine rtl
`timescale 1ns / 100ps

module unitary_gate_apply_engine_test;

   localparam logic [2:0] OP_UNDEF_LO = 3'd6;
   localparam logic [2:0] OP_UNDEF_HI = 3'd7;
   localparam int MAXQ = ugae_pkg::MAX_QUBITS_DEFAULT;
   localparam int MAXD = 1 << MAXQ;
   localparam int STALL_LIMIT = 40000;
   localparam int SETTLE = 12;

   typedef enum logic [1:0] {K_XACT, K_CFG, K_PAUSE} kind_type;

   typedef struct {
      kind_type          kind;
      logic [2:0]        op;
      logic [3:0]        row;
      logic [3:0]        col;
      logic signed [31:0] vr;
      logic signed [31:0] vi;
      logic [3:0]        slot;
      logic [1:0]        q0;
      logic [1:0]        q1;
      logic [2:0]        cfg;
   } txn_type;

   typedef struct {
      logic signed [31:0] rr;
      logic signed [31:0] ri;
      logic [1:0]         st;
   } answer_type;

   logic clock = 1'b0, reset = 1'b1, start = 1'b0, busy;
   logic [2:0] req_operation = '0;
   logic [3:0] req_row = '0, req_col = '0, req_gate_slot = '0;
   logic signed [31:0] req_value_real = '0, req_value_imag = '0;
   logic [1:0] req_first_qubit = '0, req_second_qubit = '0;
   logic csr_we = 1'b0;
   logic [2:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_read_real, rsp_read_imag;
   logic [1:0] rsp_status;

   txn_type pending_q[$];
   answer_type answer_q[$];
   logic signed [31:0] mat_re [MAXD*MAXD];
   logic signed [31:0] mat_im [MAXD*MAXD];
   logic signed [31:0] gate_re [16];
   logic signed [31:0] gate_im [16];
   logic [2:0] qubit_reg;
   int errors = 0;
   int sent = 0;
   int settle_cnt = 0;
   int stall_cnt = 0;
   int gen_n;

   unitary_gate_apply_engine u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_row(req_row), .req_col(req_col),
      .req_value_real(req_value_real), .req_value_imag(req_value_imag),
      .req_gate_slot(req_gate_slot), .req_first_qubit(req_first_qubit),
      .req_second_qubit(req_second_qubit), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_read_real(rsp_read_real),
      .rsp_read_imag(rsp_read_imag), .rsp_status(rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int eff_n(logic [2:0] q);
      if (q < 1) return 1;
      if (q > MAXQ) return MAXQ;
      return int'(q);
   endfunction

   function automatic logic signed [31:0] round_sat(logic signed [71:0] acc);
      logic signed [71:0] s;
      s = acc >>> 30;
      if (s > 72'sd2147483647) return 32'h7fff_ffff;
      if (s < -72'sd2147483648) return 32'h8000_0000;
      return s[31:0];
   endfunction

   // rows of one column replaced by gate times those rows
   function automatic void mix_rows(int rows[4], int cnt, int c);
      logic signed [31:0] ore [4], oim [4];
      logic signed [71:0] are, aim;
      logic signed [63:0] gr, gi, mr, mi;
      for (int k = 0; k < cnt; k++) begin
         ore[k] = mat_re[rows[k]*MAXD + c];
         oim[k] = mat_im[rows[k]*MAXD + c];
      end
      for (int r = 0; r < cnt; r++) begin
         are = 0;
         aim = 0;
         for (int k = 0; k < cnt; k++) begin
            gr = gate_re[r*cnt + k];
            gi = gate_im[r*cnt + k];
            mr = ore[k];
            mi = oim[k];
            are = are + gr*mr - gi*mi;
            aim = aim + gr*mi + gi*mr;
         end
         mat_re[rows[r]*MAXD + c] = round_sat(are);
         mat_im[rows[r]*MAXD + c] = round_sat(aim);
      end
   endfunction

   function automatic answer_type predict_answer(logic [2:0] op, logic [3:0] row,
         logic [3:0] col, logic signed [31:0] vr, logic signed [31:0] vi,
         logic [3:0] slot, logic [1:0] q0, logic [1:0] q1);
      answer_type a;
      int n, dim, bj, bk;
      int rows[4];
      a = '{0, 0, ugae_pkg::ST_OK};
      n = eff_n(qubit_reg);
      dim = 1 << n;
      case (op) inside
         ugae_pkg::OP_IDENTITY: begin
            for (int r = 0; r < dim; r++)
               for (int c = 0; c < dim; c++) begin
                  mat_re[r*MAXD + c] = (r == c) ? ugae_pkg::Q_ONE : 0;
                  mat_im[r*MAXD + c] = 0;
               end
         end
         ugae_pkg::OP_WRITE, ugae_pkg::OP_READ: begin
            if (row >= dim || col >= dim) a.st = ugae_pkg::ST_RANGE;
            else if (op == ugae_pkg::OP_WRITE) begin
               mat_re[row*MAXD + col] = vr;
               mat_im[row*MAXD + col] = vi;
            end else begin
               a.rr = mat_re[row*MAXD + col];
               a.ri = mat_im[row*MAXD + col];
            end
         end
         ugae_pkg::OP_LOAD_GATE: begin
            gate_re[slot] = vr;
            gate_im[slot] = vi;
         end
         ugae_pkg::OP_APPLY_TWO: begin
            if (!(q0 < q1 && q1 < n)) a.st = ugae_pkg::ST_PAIR;
            else begin
               bj = 1 << (n - 1 - q0);
               bk = 1 << (n - 1 - q1);
               for (int r = 0; r < dim; r++) begin
                  if ((r & (bj | bk)) == 0) begin
                     rows = '{r, r | bk, r | bj, r | bj | bk};
                     for (int c = 0; c < dim; c++) mix_rows(rows, 4, c);
                  end
               end
            end
         end
         ugae_pkg::OP_APPLY_ONE: begin
            if (n != 1) a.st = ugae_pkg::ST_ONEQ;
            else begin
               rows = '{0, 1, 0, 0};
               for (int c = 0; c < 2; c++) mix_rows(rows, 2, c);
            end
         end
         default: a.st = ugae_pkg::ST_RANGE;
      endcase
      return a;
   endfunction

   // driver
   always @(posedge clock) begin
      logic nxt_start, nxt_we, quiet;
      txn_type t;
      nxt_start = start;
      nxt_we = 1'b0;
      quiet = (sent >= 400 && sent < 600);
      if (reset) begin
         nxt_start = 1'b0;
      end else begin
         if (start && !busy) begin
            answer_q.push_back(predict_answer(req_operation, req_row, req_col,
               req_value_real, req_value_imag, req_gate_slot, req_first_qubit,
               req_second_qubit));
            nxt_start = 1'b0;
            sent++;
         end
         if (answer_q.size() == 0 && !busy && !nxt_start) settle_cnt++;
         else settle_cnt = 0;
         if (!nxt_start && pending_q.size() > 0) begin
            t = pending_q[0];
            case (t.kind)
               K_XACT: begin
                  if (quiet || $urandom_range(99) >= 13) begin
                     req_operation <= t.op;
                     req_row <= t.row;
                     req_col <= t.col;
                     req_value_real <= t.vr;
                     req_value_imag <= t.vi;
                     req_gate_slot <= t.slot;
                     req_first_qubit <= t.q0;
                     req_second_qubit <= t.q1;
                     nxt_start = 1'b1;
                     void'(pending_q.pop_front());
                  end
               end
               K_CFG: begin
                  if (settle_cnt >= SETTLE) begin
                     csr_wdata <= t.cfg;
                     nxt_we = 1'b1;
                     qubit_reg = t.cfg;
                     settle_cnt = 0;
                     void'(pending_q.pop_front());
                  end
               end
               default: begin
                  if (answer_q.size() == 0) void'(pending_q.pop_front());
               end
            endcase
         end
      end
      start <= nxt_start;
      csr_we <= nxt_we;
   end

   // monitor
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            $display("%0t unexpected transaction: real %h imag %h status %0d",
               $time, rsp_read_real, rsp_read_imag, rsp_status);
            errors++;
         end else begin
            e = answer_q.pop_front();
            if (rsp_read_real !== e.rr) begin
               $display("%0t read_real expected %h actual %h", $time, e.rr, rsp_read_real);
               errors++;
            end
            if (rsp_read_imag !== e.ri) begin
               $display("%0t read_imag expected %h actual %h", $time, e.ri, rsp_read_imag);
               errors++;
            end
            if (rsp_status !== e.st) begin
               $display("%0t status expected %0d actual %0d", $time, e.st, rsp_status);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed(32'($urandom_range(32'h7fff_ffff))) >>> 1;
         2: return -($signed(32'($urandom_range(32'h7fff_ffff))) >>> 1);
         default: return $urandom_range(1) ? 32'h4000_0000 : 32'hc000_0000;
      endcase
   endfunction

   task automatic add_txn(logic [2:0] op, logic [3:0] row, logic [3:0] col,
         logic signed [31:0] vr, logic signed [31:0] vi, logic [3:0] slot,
         logic [1:0] q0, logic [1:0] q1);
      pending_q.push_back('{K_XACT, op, row, col, vr, vi, slot, q0, q1, 3'd0});
   endtask

   task automatic add_cfg(logic [2:0] q);
      pending_q.push_back('{K_CFG, 0, 0, 0, 0, 0, 0, 0, 0, q});
      gen_n = eff_n(q);
      // fill the active block and all gate slots before anything reads them
      add_txn(ugae_pkg::OP_IDENTITY, 4'($urandom), 4'($urandom), $urandom, $urandom,
         4'($urandom), 2'($urandom), 2'($urandom));
      for (int s = 0; s < 16; s++)
         add_txn(ugae_pkg::OP_LOAD_GATE, 4'($urandom), 4'($urandom), rand_value(),
            rand_value(), 4'(s), 2'($urandom), 2'($urandom));
   endtask

   task automatic add_random();
      int dim, w, a, b;
      logic [3:0] row, col, slot;
      logic [1:0] q0, q1;
      dim = 1 << gen_n;
      w = $urandom_range(99);
      row = $urandom_range(4) == 0 ? 4'($urandom) : 4'($urandom_range(dim - 1));
      col = $urandom_range(4) == 0 ? 4'($urandom) : 4'($urandom_range(dim - 1));
      slot = 4'($urandom);
      q0 = 2'($urandom);
      q1 = 2'($urandom);
      if (gen_n > 1 && $urandom_range(4) != 0) begin
         a = $urandom_range(gen_n - 2);
         b = $urandom_range(gen_n - 1, a + 1);
         q0 = 2'(a);
         q1 = 2'(b);
      end
      if (w < 3)
         add_txn(ugae_pkg::OP_IDENTITY, row, col, $urandom, $urandom, slot, q0, q1);
      else if (w < 35)
         add_txn(ugae_pkg::OP_WRITE, row, col, rand_value(), rand_value(), slot, q0, q1);
      else if (w < 68)
         add_txn(ugae_pkg::OP_READ, row, col, $urandom, $urandom, slot, q0, q1);
      else if (w < 86)
         add_txn(ugae_pkg::OP_LOAD_GATE, row, col, rand_value(), rand_value(), slot,
            q0, q1);
      else if (w < 93)
         add_txn(ugae_pkg::OP_APPLY_TWO, row, col, $urandom, $urandom, slot, q0, q1);
      else if (w < 98)
         add_txn(ugae_pkg::OP_APPLY_ONE, row, col, $urandom, $urandom, slot, q0, q1);
      else
         add_txn($urandom_range(1) ? OP_UNDEF_LO : OP_UNDEF_HI, row, col,
            $urandom, $urandom, slot, q0, q1);
   endtask

   initial begin
      logic [2:0] settings [7];
      settings = '{3'd2, 3'd7, 3'd0, 3'd3, 3'd4, 3'd1, 3'd5};
      qubit_reg = 3'd1;
      for (int i = 0; i < MAXD*MAXD; i++) begin
         mat_re[i] = 0;
         mat_im[i] = 0;
      end
      for (int i = 0; i < 16; i++) begin
         gate_re[i] = 0;
         gate_im[i] = 0;
      end

      // directed part at reset size, one qubit
      add_cfg(3'd1);
      add_txn(ugae_pkg::OP_WRITE, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
      add_txn(ugae_pkg::OP_WRITE, 1, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
      add_txn(ugae_pkg::OP_READ, 0, 1, 0, 0, 0, 0, 0);
      add_txn(ugae_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0);
      add_txn(ugae_pkg::OP_READ, 4'hf, 0, 0, 0, 0, 0, 0);
      add_txn(ugae_pkg::OP_WRITE, 0, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 4'hf, 3, 3);
      add_txn(ugae_pkg::OP_LOAD_GATE, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
      add_txn(ugae_pkg::OP_LOAD_GATE, 0, 0, 32'h8000_0000, 32'h8000_0000, 3, 0, 0);
      add_txn(ugae_pkg::OP_APPLY_ONE, 0, 0, 0, 0, 0, 0, 0);
      add_txn(ugae_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
      add_txn(ugae_pkg::OP_APPLY_TWO, 0, 0, 0, 0, 0, 0, 1);
      add_txn(OP_UNDEF_LO, 0, 0, 0, 0, 0, 0, 0);
      add_txn(OP_UNDEF_HI, 4'hf, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 4'hf, 3, 3);
      add_cfg(3'd4);
      add_txn(ugae_pkg::OP_APPLY_ONE, 0, 0, 0, 0, 0, 0, 0);
      add_txn(ugae_pkg::OP_APPLY_TWO, 0, 0, 0, 0, 0, 2, 2);
      add_txn(ugae_pkg::OP_APPLY_TWO, 0, 0, 0, 0, 0, 3, 1);
      add_txn(ugae_pkg::OP_APPLY_TWO, 0, 0, 0, 0, 0, 0, 3);
      add_txn(ugae_pkg::OP_READ, 4'hf, 4'hf, 0, 0, 0, 0, 0);
      add_txn(ugae_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
      pending_q.push_back('{K_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 0});

      for (int p = 0; p < 7; p++) begin
         add_cfg(settings[p]);
         for (int i = 0; i < 143; i++) add_random();
         if (p == 3) pending_q.push_back('{K_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !start && answer_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && answer_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
